/* hdl/stun_message_parser_defines.svh */
// Assertion macros shared by the STUN message parser modules.
// Every module that includes this file has ports named clock and reset.
`ifndef STUN_MESSAGE_PARSER_DEFINES_SVH
`define STUN_MESSAGE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STUN_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STUN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/stun_pkg.sv */
// Types, codes and helper functions of the STUN message parser.
// Used by stun_parse, stun_rsp_fifo, stun_message_parser and stun_result_checker.
package stun_pkg;

   localparam int MAX_RESULTS = 3;

   localparam logic [2:0] K_TXN      = 3'd0;
   localparam logic [2:0] K_VAL      = 3'd1;
   localparam logic [2:0] K_COMPLETE = 3'd2;
   localparam logic [2:0] K_DROP     = 3'd3;
   localparam logic [2:0] K_ACCEPT   = 3'd4;
   localparam logic [2:0] K_SHORT    = 3'd5;
   localparam logic [2:0] K_BADCOOK  = 3'd6;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_AHDR   = 2'd1;
   localparam logic [1:0] PH_AVAL   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [4:0] HDR_BYTES = 5'd20;
   localparam logic [4:0] HDR_LAST  = 5'd19;
   localparam logic [4:0] TXN_START = 5'd8;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value_byte;
      logic [15:0] byte_index;
      logic [15:0] attribute_type;
      logic [15:0] attribute_length;
      logic [15:0] msg_type;
      logic [15:0] msg_length;
      logic        run_end;
   } result_type;

   function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = 8'h21;
         2'd1: b = 8'h12;
         2'd2: b = 8'hA4;
         default: b = 8'h42;
      endcase
      return b;
   endfunction

   function automatic logic [16:0] padded_len(input logic [15:0] len);
      return ({1'b0, len} + 17'd3) & ~17'd3;
   endfunction

   function automatic result_type make_res(input logic [2:0] kind,
                                           input logic [7:0] vb,
                                           input logic [15:0] idx,
                                           input logic [15:0] at,
                                           input logic [15:0] al,
                                           input logic [15:0] mt,
                                           input logic [15:0] ml);
      result_type r;
      r.kind             = kind;
      r.value_byte       = vb;
      r.byte_index       = idx;
      r.attribute_type   = at;
      r.attribute_length = al;
      r.msg_type         = mt;
      r.msg_length       = ml;
      r.run_end          = 1'b0;
      return r;
   endfunction

endpackage

/* hdl/stun_parse.sv */
// Parser state and per-byte decode of the STUN header and attributes.
// Depends on stun_pkg and stun_message_parser_defines.svh.
`include "stun_message_parser_defines.svh"

module stun_parse import stun_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type res [MAX_RESULTS],
   output logic [1:0] res_count
);

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  header_pos_ff, header_pos_in;
   logic        cookie_ok_ff, cookie_ok_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] atype_ff, atype_in;
   logic [15:0] alen_ff, alen_in;
   logic [15:0] attr_pos_ff, attr_pos_in;
   logic [1:0]  hdr_pos_ff, hdr_pos_in;

   logic        finish;
   logic [16:0] pos_next;
   logic [16:0] used;
   logic [1:0]  n;

   always_comb begin
      phase_in      = phase_ff;
      header_pos_in = header_pos_ff;
      cookie_ok_in  = cookie_ok_ff;
      type_in       = type_ff;
      length_in     = length_ff;
      remaining_in  = remaining_ff;
      atype_in      = atype_ff;
      alen_in       = alen_ff;
      attr_pos_in   = attr_pos_ff;
      hdr_pos_in    = hdr_pos_ff;
      finish        = 1'b0;
      pos_next      = {1'b0, attr_pos_ff} + 17'd1;
      used          = '0;
      n             = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      case (phase_ff)
         PH_HEADER: begin
            if (header_pos_ff < 5'd2) begin
               type_in = {type_ff[7:0], data_byte};
            end else if (header_pos_ff < 5'd4) begin
               length_in = {length_ff[7:0], data_byte};
            end else if (header_pos_ff < 5'd8) begin
               if (data_byte != cookie_byte(header_pos_ff[1:0])) begin
                  cookie_ok_in = 1'b0;
               end
            end else if (cookie_ok_ff) begin
               res[n] = make_res(K_TXN, data_byte, {11'd0, header_pos_ff - TXN_START},
                                 16'd0, 16'd0, type_ff, length_ff);
               n = n + 2'd1;
            end
            if (header_pos_ff == HDR_LAST) begin
               header_pos_in = 5'd0;
               if (!cookie_ok_ff || length_ff == 16'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  remaining_in = length_ff;
                  hdr_pos_in   = 2'd0;
                  phase_in     = PH_AHDR;
               end
            end else begin
               header_pos_in = header_pos_ff + 5'd1;
            end
         end
         PH_AHDR: begin
            if (hdr_pos_ff < 2'd2) begin
               atype_in = {atype_ff[7:0], data_byte};
            end else begin
               alen_in = {alen_ff[7:0], data_byte};
            end
            if (hdr_pos_ff == 2'd3) begin
               hdr_pos_in  = 2'd0;
               attr_pos_in = 16'd0;
               if (alen_in == 16'd0) begin
                  res[n] = make_res(K_COMPLETE, 8'd0, 16'd0, atype_in, alen_in,
                                    type_ff, length_ff);
                  n = n + 2'd1;
                  finish = 1'b1;
               end else begin
                  phase_in = PH_AVAL;
               end
            end else begin
               hdr_pos_in = hdr_pos_ff + 2'd1;
            end
         end
         PH_AVAL: begin
            if (attr_pos_ff < alen_ff) begin
               res[n] = make_res(K_VAL, data_byte, attr_pos_ff, atype_ff, alen_ff,
                                 type_ff, length_ff);
               n = n + 2'd1;
            end
            if (pos_next >= padded_len(alen_ff)) begin
               res[n] = make_res(K_COMPLETE, 8'd0, 16'd0, atype_ff, alen_ff,
                                 type_ff, length_ff);
               n = n + 2'd1;
               finish = 1'b1;
            end else begin
               attr_pos_in = pos_next[15:0];
            end
         end
         default: begin
         end
      endcase

      if (finish) begin
         used = 17'd4 + padded_len(alen_in);
         if (used >= {1'b0, remaining_ff}) begin
            remaining_in = 16'd0;
            phase_in     = PH_DONE;
         end else begin
            remaining_in = remaining_ff - used[15:0];
            phase_in     = PH_AHDR;
         end
         attr_pos_in = 16'd0;
         hdr_pos_in  = 2'd0;
      end

      if (last_byte) begin
         if (phase_in == PH_AVAL) begin
            res[n] = make_res(K_DROP, 8'd0, 16'd0, atype_in, alen_in, type_in, length_in);
            n = n + 2'd1;
         end
         if (phase_in == PH_HEADER) begin
            res[n] = make_res(K_SHORT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
         end else if (!cookie_ok_in) begin
            res[n] = make_res(K_BADCOOK, 8'd0, 16'd0, 16'd0, 16'd0, type_in, length_in);
         end else begin
            res[n] = make_res(K_ACCEPT, 8'd0, 16'd0, 16'd0, 16'd0, type_in, length_in);
         end
         n = n + 2'd1;
         phase_in      = PH_HEADER;
         header_pos_in = 5'd0;
         cookie_ok_in  = 1'b1;
         type_in       = 16'd0;
         length_in     = 16'd0;
         remaining_in  = 16'd0;
         atype_in      = 16'd0;
         alen_in       = 16'd0;
         attr_pos_in   = 16'd0;
         hdr_pos_in    = 2'd0;
      end

      if (n != 2'd0) begin
         res[n - 2'd1].run_end = 1'b1;
      end
      res_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         header_pos_ff <= 5'd0;
         cookie_ok_ff  <= 1'b1;
         type_ff       <= 16'd0;
         length_ff     <= 16'd0;
         remaining_ff  <= 16'd0;
         atype_ff      <= 16'd0;
         alen_ff       <= 16'd0;
         attr_pos_ff   <= 16'd0;
         hdr_pos_ff    <= 2'd0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         header_pos_ff <= header_pos_in;
         cookie_ok_ff  <= cookie_ok_in;
         type_ff       <= type_in;
         length_ff     <= length_in;
         remaining_ff  <= remaining_in;
         atype_ff      <= atype_in;
         alen_ff       <= alen_in;
         attr_pos_ff   <= attr_pos_in;
         hdr_pos_ff    <= hdr_pos_in;
      end
   end

   `STUN_ASSERT_SAME(a_hdr_pos_range, phase_ff == PH_HEADER, header_pos_ff < HDR_BYTES, "header position out of range")
   `STUN_ASSERT_SAME(a_attr_pos_range, phase_ff == PH_AVAL, 17'(attr_pos_ff) < padded_len(alen_ff), "attribute position past padded length")
   `STUN_ASSERT_NEXT(a_reset_after_last, step_en && last_byte, phase_ff == PH_HEADER && header_pos_ff == 5'd0 && cookie_ok_ff, "state not cleared after final byte")

endmodule

/* hdl/stun_rsp_fifo.sv */
// Result queue that takes up to three results per cycle and delivers one per cycle while out_ready is high.
// Depends on stun_pkg and stun_message_parser_defines.svh.
`include "stun_message_parser_defines.svh"

module stun_rsp_fifo import stun_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  logic [1:0] push_count,
   input  result_type push_data [MAX_RESULTS],
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type    mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] w1, w2, w3;
   logic          pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign w1        = ptr_inc(wr_ptr_ff);
   assign w2        = ptr_inc(w1);
   assign w3        = ptr_inc(w2);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CW'(DEPTH - MAX_RESULTS));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_en) begin
         case (push_count)
            2'd1: wr_ptr_in = w1;
            2'd2: wr_ptr_in = w2;
            2'd3: wr_ptr_in = w3;
            default: wr_ptr_in = wr_ptr_ff;
         endcase
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (push_en ? CW'(push_count) : '0) - (pop ? CW'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         if (push_count >= 2'd1) begin
            mem_ff[wr_ptr_ff] <= push_data[0];
         end
         if (push_count >= 2'd2) begin
            mem_ff[w1] <= push_data[1];
         end
         if (push_count == 2'd3) begin
            mem_ff[w2] <= push_data[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `STUN_ASSERT_SAME(a_push_has_room, push_en, room, "results pushed without room")
   `STUN_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "queue count above depth")

endmodule

/* hdl/stun_message_parser.sv */
// Top level of the STUN message parser: input register, parser and result queue.
// Depends on stun_pkg, stun_parse, stun_rsp_fifo and stun_message_parser_defines.svh.
//
// Usage: one datagram byte is transferred per req_ handshake, in network order,
// with req_last_byte set on the final byte. The block reads the 20-byte header,
// emits the transaction ID bytes when the cookie matches, walks the attributes
// and emits their value bytes, completion and drop events, and ends each
// datagram with one verdict result. Each result is one rsp_ transfer; rsp_run_end
// marks the last result caused by a given byte, and a byte may cause zero to three.
// A transferred byte is held in the input register and decoded once the result
// queue has room; its results are written into the queue and offered on rsp_ from there.
// Throughput is one byte per cycle while each byte causes at most one result and
// rsp_ready stays high; bytes that cause more are paid for by the one-result-per-cycle output port.
// The result queue holds RSP_DEPTH results; the decode waits while fewer than
// three entries are free, so a stalled receiver backs up into req_ready.
// Reset clears the parser to the start of a datagram and empties the queue.
// After each verdict the parser returns to that same starting state.
`include "stun_message_parser_defines.svh"

module stun_message_parser import stun_pkg::*; #(
   parameter int RSP_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_value_byte,
   output logic [15:0] rsp_byte_index,
   output logic [15:0] rsp_attribute_type,
   output logic [15:0] rsp_attribute_length,
   output logic [15:0] rsp_msg_type,
   output logic [15:0] rsp_msg_length,
   output logic        rsp_run_end
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       room;
   logic       step;
   result_type res [MAX_RESULTS];
   logic [1:0] res_count;
   result_type head;

   assign step      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   stun_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .res       (res),
      .res_count (res_count)
   );

   stun_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (step),
      .push_count (res_count),
      .push_data  (res),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (head)
   );

   assign rsp_kind             = head.kind;
   assign rsp_value_byte       = head.value_byte;
   assign rsp_byte_index       = head.byte_index;
   assign rsp_attribute_type   = head.attribute_type;
   assign rsp_attribute_length = head.attribute_length;
   assign rsp_msg_type         = head.msg_type;
   assign rsp_msg_length       = head.msg_length;
   assign rsp_run_end          = head.run_end;

   `STUN_ASSERT_NEXT(a_held_byte_kept, in_valid_ff && !step, in_valid_ff && $stable(in_data_ff) && $stable(in_last_ff), "held input byte lost before decode")

endmodule

/* tb/stun_result_checker.sv */
// Result checker for the STUN message parser: predicts the results of every byte transfer
// and compares them with the rsp_ transfers in order. Depends on stun_pkg.
`timescale 1ns / 1ps

module stun_result_checker import stun_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_value_byte,
   input  logic [15:0] rsp_byte_index,
   input  logic [15:0] rsp_attribute_type,
   input  logic [15:0] rsp_attribute_length,
   input  logic [15:0] rsp_msg_type,
   input  logic [15:0] rsp_msg_length,
   input  logic        rsp_run_end,
   output int          fail_count,
   output int          expected_count
);

   localparam logic [31:0] MAGIC = 32'h2112A442;

   logic [1:0]  phase_q;
   logic [4:0]  hdr_pos;
   logic        cookie_good;
   logic [15:0] msg_type_q;
   logic [15:0] msg_len_q;
   logic [16:0] left_len;
   logic [15:0] atype_q;
   logic [15:0] attr_len_q;
   logic [16:0] val_pos;
   logic [1:0]  ahdr_pos;

   result_type  byte_res[$];
   result_type  pending_results[$];
   result_type  got;
   result_type  want;

   task automatic clear_parse();
      phase_q     = PH_HEADER;
      hdr_pos     = '0;
      cookie_good = 1'b1;
      msg_type_q  = '0;
      msg_len_q   = '0;
      left_len    = '0;
      atype_q     = '0;
      attr_len_q  = '0;
      val_pos     = '0;
      ahdr_pos    = '0;
   endtask

   function automatic logic [16:0] padded_bytes();
      return ({1'b0, attr_len_q} + 17'd3) & ~17'd3;
   endfunction

   task automatic note(input logic [2:0] kind, input logic [7:0] vb, input logic [15:0] idx,
                       input logic with_attr, input logic with_msg);
      result_type r;
      r = '0;
      r.kind       = kind;
      r.value_byte = vb;
      r.byte_index = idx;
      if (with_attr) begin
         r.attribute_type   = atype_q;
         r.attribute_length = attr_len_q;
      end
      if (with_msg) begin
         r.msg_type   = msg_type_q;
         r.msg_length = msg_len_q;
      end
      byte_res = {byte_res, r};
   endtask

   task automatic close_attr();
      int used;
      used = 4 + int'(padded_bytes());
      if (used >= int'(left_len)) begin
         left_len = '0;
         phase_q  = PH_DONE;
      end else begin
         left_len = left_len - 17'(used);
         phase_q  = PH_AHDR;
      end
      val_pos  = '0;
      ahdr_pos = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin);
      int n;
      byte_res = {};
      case (phase_q)
         PH_HEADER: begin
            if (hdr_pos < 5'd2) begin
               msg_type_q = {msg_type_q[7:0], b};
            end else if (hdr_pos < 5'd4) begin
               msg_len_q = {msg_len_q[7:0], b};
            end else if (hdr_pos < TXN_START) begin
               if (b != MAGIC[31 - 8 * (hdr_pos - 5'd4) -: 8])
                  cookie_good = 1'b0;
            end else if (cookie_good) begin
               note(K_TXN, b, 16'(hdr_pos - TXN_START), 1'b0, 1'b1);
            end
            if (hdr_pos == HDR_LAST) begin
               hdr_pos = '0;
               if (!cookie_good || msg_len_q == 16'd0) begin
                  phase_q = PH_DONE;
               end else begin
                  left_len = {1'b0, msg_len_q};
                  ahdr_pos = '0;
                  phase_q  = PH_AHDR;
               end
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         PH_AHDR: begin
            if (ahdr_pos < 2'd2)
               atype_q = {atype_q[7:0], b};
            else
               attr_len_q = {attr_len_q[7:0], b};
            if (ahdr_pos == 2'd3) begin
               ahdr_pos = '0;
               val_pos  = '0;
               if (attr_len_q == 16'd0) begin
                  note(K_COMPLETE, 8'd0, 16'd0, 1'b1, 1'b1);
                  close_attr();
               end else begin
                  phase_q = PH_AVAL;
               end
            end else begin
               ahdr_pos = ahdr_pos + 2'd1;
            end
         end
         PH_AVAL: begin
            if (val_pos < {1'b0, attr_len_q})
               note(K_VAL, b, val_pos[15:0], 1'b1, 1'b1);
            val_pos = val_pos + 17'd1;
            if (val_pos >= padded_bytes()) begin
               note(K_COMPLETE, 8'd0, 16'd0, 1'b1, 1'b1);
               close_attr();
            end
         end
         default: ;
      endcase
      if (fin) begin
         if (phase_q == PH_AVAL)
            note(K_DROP, 8'd0, 16'd0, 1'b1, 1'b1);
         if (phase_q == PH_HEADER)
            note(K_SHORT, 8'd0, 16'd0, 1'b0, 1'b0);
         else if (!cookie_good)
            note(K_BADCOOK, 8'd0, 16'd0, 1'b0, 1'b1);
         else
            note(K_ACCEPT, 8'd0, 16'd0, 1'b0, 1'b1);
         clear_parse();
      end
      n = byte_res.size();
      if (n > 0)
         byte_res[n - 1].run_end = 1'b1;
      pending_results = {pending_results, byte_res};
   endtask

   function automatic string show(input result_type r);
      return $sformatf("kind=%0d byte=%02h idx=%0d atype=%04h alen=%0d mtype=%04h mlen=%0d end=%0b",
                       r.kind, r.value_byte, r.byte_index, r.attribute_type,
                       r.attribute_length, r.msg_type, r.msg_length, r.run_end);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         pending_results.delete();
         fail_count = 0;
         expected_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind             = rsp_kind;
            got.value_byte       = rsp_value_byte;
            got.byte_index       = rsp_byte_index;
            got.attribute_type   = rsp_attribute_type;
            got.attribute_length = rsp_attribute_length;
            got.msg_type         = rsp_msg_type;
            got.msg_length       = rsp_msg_length;
            got.run_end          = rsp_run_end;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result transfer with none expected: %s", $realtime, show(got));
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result differs\n   expected %s\n   actual   %s",
                              $realtime, show(want), show(got));
               end
            end
         end
         if (req_valid && req_ready)
            parse_byte(req_data_byte, req_last_byte);
         expected_count <= pending_results.size();
      end
   end

endmodule

/* tb/tb_top.sv */
// Top of the STUN message parser testbench: clock, reset, datagram stimulus, receiver
// stalls and the verdict. Depends on stun_message_parser and stun_result_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [31:0] MAGIC       = 32'h2112A442;
   localparam int          STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_value_byte;
   logic [15:0] rsp_byte_index;
   logic [15:0] rsp_attribute_type;
   logic [15:0] rsp_attribute_length;
   logic [15:0] rsp_msg_type;
   logic [15:0] rsp_msg_length;
   logic        rsp_run_end;

   int          fail_count;
   int          expected_count;
   int          idle_cycles = 0;
   int          ready_hold = 0;
   int          sent = 0;
   logic        quiet = 1'b0;
   logic        drained = 1'b0;
   logic [7:0]  dgram[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stun_message_parser i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_value_byte       (rsp_value_byte),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_attribute_type   (rsp_attribute_type),
      .rsp_attribute_length (rsp_attribute_length),
      .rsp_msg_type         (rsp_msg_type),
      .rsp_msg_length       (rsp_msg_length),
      .rsp_run_end          (rsp_run_end)
   );

   stun_result_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_value_byte       (rsp_value_byte),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_attribute_type   (rsp_attribute_type),
      .rsp_attribute_length (rsp_attribute_length),
      .rsp_msg_type         (rsp_msg_type),
      .rsp_msg_length       (rsp_msg_length),
      .rsp_run_end          (rsp_run_end),
      .fail_count           (fail_count),
      .expected_count       (expected_count)
   );

   function automatic int pause_len();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 6);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= pause_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("stun_message_parser: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fin);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pause_len()) @(posedge clock);
      end
   endtask

   task automatic send_dgram();
      for (int i = 0; i < dgram.size(); i++)
         push_byte(dgram[i], i == dgram.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
   endtask

   task automatic put_header(input logic [15:0] mtype, input logic [15:0] mlen,
                             input logic good);
      int bad_at;
      bad_at = good ? -1 : $urandom_range(0, 3);
      dgram = {dgram, mtype[15:8]};
      dgram = {dgram, mtype[7:0]};
      dgram = {dgram, mlen[15:8]};
      dgram = {dgram, mlen[7:0]};
      for (int k = 0; k < 4; k++) begin
         if (k == bad_at)
            dgram = {dgram, MAGIC[31 - 8 * k -: 8] ^ 8'($urandom_range(1, 255))};
         else
            dgram = {dgram, MAGIC[31 - 8 * k -: 8]};
      end
      repeat (12) dgram = {dgram, 8'($urandom)};
   endtask

   task automatic random_dgram();
      int          sel;
      int          alen;
      int          body_len;
      logic [15:0] declared;
      logic [7:0]  body[$];
      dgram = {};
      body  = {};
      sel   = $urandom_range(0, 15);
      if (sel == 0) begin
         put_header(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
         dgram = dgram[0:$urandom_range(0, 18)];
      end else if (sel == 1) begin
         put_header(16'($urandom), 16'($urandom), 1'b0);
         repeat ($urandom_range(0, 4)) dgram = {dgram, 8'($urandom)};
      end else if (sel == 2) begin
         put_header(16'($urandom), 16'd0, 1'b1);
         repeat ($urandom_range(0, 3)) dgram = {dgram, 8'($urandom)};
      end else if (sel == 3) begin
         put_header(16'($urandom), 16'($urandom_range(8, 65535)), 1'b1);
         declared = 16'($urandom_range(8, 65535));
         dgram = {dgram, 8'($urandom)};
         dgram = {dgram, 8'($urandom)};
         dgram = {dgram, declared[15:8]};
         dgram = {dgram, declared[7:0]};
         repeat ($urandom_range(1, 12)) dgram = {dgram, 8'($urandom)};
      end else begin
         repeat ($urandom_range(1, 3)) begin
            alen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
            body = {body, 8'($urandom)};
            body = {body, 8'($urandom)};
            body = {body, 8'(alen >> 8)};
            body = {body, 8'(alen)};
            repeat (alen) body = {body, 8'($urandom)};
            repeat ((4 - alen % 4) % 4) body = {body, 8'($urandom)};
         end
         body_len = body.size();
         case ($urandom_range(0, 5))
            0: declared = 16'($urandom_range(1, body_len - 1));
            1: declared = 16'(body_len + $urandom_range(1, 6));
            default: declared = 16'(body_len);
         endcase
         put_header(16'($urandom), declared, 1'b1);
         case ($urandom_range(0, 5))
            0: body = body[0:$urandom_range(0, body_len - 2)];
            1: repeat ($urandom_range(1, 4)) body = {body, 8'($urandom)};
            default: ;
         endcase
         dgram = {dgram, body};
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      dgram = {8'hFF};
      send_dgram();
      dgram = {};
      put_header(16'hFFFF, 16'd4, 1'b1);
      dgram[8]  = 8'h00;
      dgram[19] = 8'hFF;
      repeat (4) dgram = {dgram, 8'h00};
      send_dgram();

      while (sent < 170) begin
         quiet <= ($urandom_range(0, 4) == 0);
         random_dgram();
         send_dgram();
         if (!drained || $urandom_range(0, 5) == 0) begin
            drain();
            drained = 1'b1;
         end
      end

      drain();
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("stun_message_parser: match");
      else
         $display("stun_message_parser: mismatch");
      $finish;
   end

endmodule
